// ----- design/rotation_matrix_to_quaternion_top_defines.svh -----
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle, clocked on clk_i
`define RMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define RMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rmq_pkg.sv -----
// types and constants shared by the rotation matrix to quaternion block
`default_nettype none

package rmq_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned QuatWW = 15;

  typedef struct packed {
    logic signed [ElemW-1:0] m_c0_r0;
    logic signed [ElemW-1:0] m_c1_r1;
    logic signed [ElemW-1:0] m_c2_r2;
    logic signed [ElemW-1:0] m_c2_r1;
    logic signed [ElemW-1:0] m_c1_r2;
    logic signed [ElemW-1:0] m_c0_r2;
    logic signed [ElemW-1:0] m_c2_r0;
    logic signed [ElemW-1:0] m_c1_r0;
    logic signed [ElemW-1:0] m_c0_r1;
  } matrix_t;

  typedef struct packed {
    logic        [QuatWW-1:0] quat_w;
    logic signed [ElemW-1:0]  quat_x;
    logic signed [ElemW-1:0]  quat_y;
    logic signed [ElemW-1:0]  quat_z;
  } quat_t;

endpackage

`default_nettype wire

// ----- design/rotation_matrix_to_quaternion_top.sv -----
// rotation matrix to inverse-rotation quaternion, fully pipelined
//
// usage:
//   start_i with matrix_i offers one matrix; it is taken at a rising edge
//   where start_i is high and busy_o is low. busy_o stays low, so a new
//   matrix may be offered in every cycle.
//   each result appears on quat_o for exactly one cycle with done_o high.
//   results come out in the order the matrices went in, one per matrix.
// stages: one front stage for saturation and radicands, FRAC_BITS + 2
//   square root stages (one root bit each, four lanes side by side) and
//   one output register.
// throughput: one matrix per cycle.
// reset: clears every valid bit; items in flight are dropped and done_o
//   stays low until new matrices reach the end of the pipe.
// the receiver cannot hold results off, and the pipe never stalls.
`default_nettype none
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rotation_matrix_to_quaternion_top #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  output logic             busy_o,
  input  rmq_pkg::matrix_t matrix_i,
  output logic             done_o,
  output rmq_pkg::quat_t   quat_o
);

  localparam int unsigned EW  = rmq_pkg::ElemW;
  localparam int unsigned SW  = (FRAC_BITS + 2 > EW + 1) ? FRAC_BITS + 2 : EW + 1;
  localparam int unsigned RW  = SW + 2;
  localparam int unsigned QW  = FRAC_BITS + 2;
  localparam int unsigned XW  = 2 * QW;
  localparam int unsigned MW  = QW + 2;
  localparam int unsigned NS  = QW;
  localparam int unsigned LAT = NS + 2;

  localparam logic signed [SW-1:0] ONE_S    = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic        [QW-1:0] ROOT_MAX = {1'b1, {(QW-1){1'b0}}};

  function automatic logic signed [SW-1:0] sat_elem(input logic signed [EW-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    if (e > ONE_S) begin
      e = ONE_S;
    end else if (e < -ONE_S) begin
      e = -ONE_S;
    end
    return e;
  endfunction

  // front stage: saturate, form the four radicands and the three signs
  logic signed [RW-1:0] d0, d1, d2, one_r;
  logic signed [RW-1:0] rad [4];
  logic signed [RW-1:0] diff_x, diff_y, diff_z;
  logic [XW-1:0]        x_in [4];
  logic [2:0]           sgn_in;

  always_comb begin
    d0     = RW'(sat_elem(matrix_i.m_c0_r0));
    d1     = RW'(sat_elem(matrix_i.m_c1_r1));
    d2     = RW'(sat_elem(matrix_i.m_c2_r2));
    one_r  = RW'(ONE_S);
    rad[0] = one_r + d0 + d1 + d2;
    rad[1] = one_r + d0 - d1 - d2;
    rad[2] = one_r - d0 + d1 - d2;
    rad[3] = one_r - d0 - d1 + d2;
    diff_x = RW'(sat_elem(matrix_i.m_c2_r1)) - RW'(sat_elem(matrix_i.m_c1_r2));
    diff_y = RW'(sat_elem(matrix_i.m_c0_r2)) - RW'(sat_elem(matrix_i.m_c2_r0));
    diff_z = RW'(sat_elem(matrix_i.m_c1_r0)) - RW'(sat_elem(matrix_i.m_c0_r1));
    sgn_in = {diff_x[RW-1], diff_y[RW-1], diff_z[RW-1]};
    for (int l = 0; l < 4; l++) begin
      // negative radicand clamps to zero
      if (rad[l][RW-1]) begin
        x_in[l] = '0;
      end else begin
        x_in[l] = XW'(rad[l][RW-2:0]) << FRAC_BITS;
      end
    end
  end

  // pipe registers: index 0 is after the front stage, index s after root step s
  logic [NS:0]   vld_q;
  logic [XW-1:0] x_q    [NS+1][4];
  logic [MW-1:0] rem_q  [NS+1][4];
  logic [QW-1:0] root_q [NS+1][4];
  logic [2:0]    sgn_q  [NS+1];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-1:0], start_i & ~busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q[0] <= sgn_in;
  end

  for (genvar l = 0; l < 4; l++) begin : g_front
    always_ff @(posedge clk_i) begin
      x_q[0][l]    <= x_in[l];
      rem_q[0][l]  <= '0;
      root_q[0][l] <= '0;
    end
  end

  // one root bit per stage: bring down two radicand bits, try root*4+1
  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      sgn_q[s+1] <= sgn_q[s];
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [MW-1:0] rem_sh, trial, rem_d;
      logic [QW-1:0] root_d;

      always_comb begin
        rem_sh = {rem_q[s][l][MW-3:0], x_q[s][l][XW-1 -: 2]};
        trial  = {root_q[s][l], 2'b01};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[s][l][QW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[s][l][QW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk_i) begin
        x_q[s+1][l]    <= x_q[s][l] << 2;
        rem_q[s+1][l]  <= rem_d;
        root_q[s+1][l] <= root_d;
      end
    end
  end

  // output stage: halve the root and apply the signs
  logic [QW-2:0]   mag [4];
  logic [EW-1:0]   mag16 [4];
  rmq_pkg::quat_t  quat_d, quat_q;
  logic            done_q;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag[l]   = root_q[NS][l][QW-1:1];
      mag16[l] = EW'(mag[l]);
    end
    quat_d.quat_w = rmq_pkg::QuatWW'(mag[0]);
    quat_d.quat_x = sgn_q[NS][2] ? -mag16[1] : mag16[1];
    quat_d.quat_y = sgn_q[NS][1] ? -mag16[2] : mag16[2];
    quat_d.quat_z = sgn_q[NS][0] ? -mag16[3] : mag16[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    quat_q <= quat_d;
  end

  assign done_o = done_q;
  assign quat_o = quat_q;

  // every accepted matrix gives exactly one result after the fixed latency
  `RMQ_ASSERT_IMP(a_lat_fwd, start_i && !busy_o, ##LAT done_o, "accepted matrix gave no result")
  `RMQ_ASSERT_IMP(a_lat_bwd, done_o, $past(start_i && !busy_o, LAT), "result without a matrix")

  for (genvar l = 0; l < 4; l++) begin : g_chk
    logic [MW-1:0] rem_lim;
    assign rem_lim = {1'b0, root_q[NS][l], 1'b0};
    // radicand never exceeds four, so the root stays within 2.0
    `RMQ_ASSERT_IMP(a_root_bound, vld_q[NS], root_q[NS][l] <= ROOT_MAX, "root out of range")
    // root step invariant: remainder at most twice the root
    `RMQ_ASSERT_NXT(a_rem_bound, vld_q[NS-1], rem_q[NS][l] <= rem_lim, "remainder too large")
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the rotation matrix to quaternion block
`timescale 1ns / 1ps

module testbench;

  localparam int FracBits = 14;
  localparam int OneFx = 1 << FracBits;
  localparam int PipeDepth = FracBits + 4;
  localparam int unsigned ElemW = rmq_pkg::ElemW;
  localparam int unsigned QuatWW = rmq_pkg::QuatWW;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  rmq_pkg::matrix_t matrix_i;
  logic             done_o;
  rmq_pkg::quat_t   quat_o;

  rmq_pkg::quat_t pending_quats[$];
  rmq_pkg::quat_t expected_quat;
  int             mismatch_count = 0;

  rotation_matrix_to_quaternion_top #(
    .FRAC_BITS(FracBits)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .matrix_i(matrix_i),
    .done_o  (done_o),
    .quat_o  (quat_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------- prediction ----------------

  function automatic int clamp_elem(logic signed [ElemW-1:0] raw);
    int v;
    v = raw;
    if (v > OneFx) v = OneFx;
    if (v < -OneFx) v = -OneFx;
    return v;
  endfunction

  // largest root whose square does not exceed v, built one bit at a time
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic int half_root(int rad);
    if (rad <= 0) return 0;
    return int'(floor_sqrt(longint'(rad) << FracBits) >> 1);
  endfunction

  function automatic rmq_pkg::quat_t quat_of_matrix(rmq_pkg::matrix_t m);
    int             d0, d1, d2;
    int             dx, dy, dz;
    int             mag_w, mag_x, mag_y, mag_z;
    rmq_pkg::quat_t q;
    d0 = clamp_elem(m.m_c0_r0);
    d1 = clamp_elem(m.m_c1_r1);
    d2 = clamp_elem(m.m_c2_r2);
    // sign differences use the saturated elements
    dx = clamp_elem(m.m_c2_r1) - clamp_elem(m.m_c1_r2);
    dy = clamp_elem(m.m_c0_r2) - clamp_elem(m.m_c2_r0);
    dz = clamp_elem(m.m_c1_r0) - clamp_elem(m.m_c0_r1);
    mag_w = half_root(OneFx + d0 + d1 + d2);
    mag_x = half_root(OneFx + d0 - d1 - d2);
    mag_y = half_root(OneFx - d0 + d1 - d2);
    mag_z = half_root(OneFx - d0 - d1 + d2);
    q.quat_w = mag_w[QuatWW-1:0];
    q.quat_x = ElemW'((dx < 0) ? -mag_x : mag_x);
    q.quat_y = ElemW'((dy < 0) ? -mag_y : mag_y);
    q.quat_z = ElemW'((dz < 0) ? -mag_z : mag_z);
    return q;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic rmq_pkg::matrix_t make_matrix(int d0, int d1, int d2, int c2r1, int c1r2,
                                                   int c0r2, int c2r0, int c1r0, int c0r1);
    rmq_pkg::matrix_t m;
    m.m_c0_r0 = ElemW'(d0);
    m.m_c1_r1 = ElemW'(d1);
    m.m_c2_r2 = ElemW'(d2);
    m.m_c2_r1 = ElemW'(c2r1);
    m.m_c1_r2 = ElemW'(c1r2);
    m.m_c0_r2 = ElemW'(c0r2);
    m.m_c2_r0 = ElemW'(c2r0);
    m.m_c1_r0 = ElemW'(c1r0);
    m.m_c0_r1 = ElemW'(c0r1);
    return m;
  endfunction

  // raw random bits over the whole matrix
  function automatic rmq_pkg::matrix_t random_raw();
    logic [5*32-1:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return noise[$bits(rmq_pkg::matrix_t)-1:0];
  endfunction

  function automatic logic signed [ElemW-1:0] to_fixed(real v);
    return ElemW'($rtoi(v * OneFx + ((v < 0.0) ? -0.5 : 0.5)));
  endfunction

  // proper rotation matrix built from a random unit quaternion
  function automatic rmq_pkg::matrix_t random_rotation();
    real              qw, qx, qy, qz, norm;
    rmq_pkg::matrix_t m;
    do begin
      qw = real'($urandom_range(0, 2000)) - 1000.0;
      qx = real'($urandom_range(0, 2000)) - 1000.0;
      qy = real'($urandom_range(0, 2000)) - 1000.0;
      qz = real'($urandom_range(0, 2000)) - 1000.0;
      norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    end while (norm < 1.0);
    qw = qw / norm;
    qx = qx / norm;
    qy = qy / norm;
    qz = qz / norm;
    m.m_c0_r0 = to_fixed(1.0 - 2.0 * (qy * qy + qz * qz));
    m.m_c1_r1 = to_fixed(1.0 - 2.0 * (qx * qx + qz * qz));
    m.m_c2_r2 = to_fixed(1.0 - 2.0 * (qx * qx + qy * qy));
    m.m_c2_r1 = to_fixed(2.0 * (qy * qz + qw * qx));
    m.m_c1_r2 = to_fixed(2.0 * (qy * qz - qw * qx));
    m.m_c0_r2 = to_fixed(2.0 * (qx * qz - qw * qy));
    m.m_c2_r0 = to_fixed(2.0 * (qx * qz + qw * qy));
    m.m_c1_r0 = to_fixed(2.0 * (qx * qy + qw * qz));
    m.m_c0_r1 = to_fixed(2.0 * (qx * qy - qw * qz));
    return m;
  endfunction

  function automatic rmq_pkg::matrix_t random_in_range();
    rmq_pkg::matrix_t m;
    m = make_matrix($urandom_range(0, 2 * OneFx) - OneFx, $urandom_range(0, 2 * OneFx) - OneFx,
                    $urandom_range(0, 2 * OneFx) - OneFx, $urandom_range(0, 2 * OneFx) - OneFx,
                    $urandom_range(0, 2 * OneFx) - OneFx, $urandom_range(0, 2 * OneFx) - OneFx,
                    $urandom_range(0, 2 * OneFx) - OneFx, $urandom_range(0, 2 * OneFx) - OneFx,
                    $urandom_range(0, 2 * OneFx) - OneFx);
    return m;
  endfunction

  // offer one matrix and hold it until the transfer happens
  task automatic send_matrix(rmq_pkg::matrix_t m);
    start_i  <= 1'b1;
    matrix_i <= m;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_quats.push_back(quat_of_matrix(m));
  endtask

  // start low with noise on the payload, which must be ignored
  task automatic idle_cycles(int n);
    start_i  <= 1'b0;
    matrix_i <= random_raw();
    repeat (n) @(posedge clk_i);
  endtask

  task automatic random_matrix(output rmq_pkg::matrix_t m);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) m = random_rotation();
    else if (pick <= 8) m = random_in_range();
    else m = random_raw();
    // equal off-diagonal pairs give zero sign differences
    if ($urandom_range(0, 7) == 0) m.m_c1_r2 = m.m_c2_r1;
    if ($urandom_range(0, 7) == 0) m.m_c2_r0 = m.m_c0_r2;
    if ($urandom_range(0, 7) == 0) m.m_c0_r1 = m.m_c1_r0;
  endtask

  // ---------------- tests ----------------

  task automatic test_directed_cases();
    int n;
    n = -OneFx;
    send_matrix(make_matrix(OneFx, OneFx, OneFx, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(OneFx, n, n, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(n, OneFx, n, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(n, n, OneFx, 0, 0, 0, 0, 0, 0));
    idle_cycles(2);
    // negative radicand for w
    send_matrix(make_matrix(n, n, n, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(0, 0, 0, n, OneFx, n, OneFx, n, OneFx));
    send_matrix(make_matrix(0, 0, 0, OneFx, n, OneFx, n, OneFx, n));
    send_matrix(make_matrix(0, 0, 0, -1, 0, -1, 0, -1, 0));
    send_matrix(make_matrix(0, 0, 0, 1, 0, 1, 0, 1, 0));
    idle_cycles(1);
    // out-of-range elements saturate before the sign differences
    send_matrix(make_matrix(16'sh7fff, 16'sh7fff, 16'sh7fff, OneFx + 1, OneFx,
                            16'sh7fff, OneFx, n - 1, n));
    send_matrix(make_matrix(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    send_matrix(make_matrix(OneFx + 1, n - 1, OneFx + 5, n - 1, n, 16'sh7fff, 16'sh8000,
                            16'sh8000, 16'sh7fff));
    send_matrix(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    // quarter turns about each axis
    send_matrix(make_matrix(0, 0, OneFx, 0, 0, 0, 0, OneFx, n));
    send_matrix(make_matrix(OneFx, 0, 0, OneFx, n, 0, 0, 0, 0));
    send_matrix(make_matrix(0, OneFx, 0, 0, 0, n, OneFx, 0, 0));
    idle_cycles(3);
    // smallest positive radicands
    send_matrix(make_matrix(1 - OneFx, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(0, 0, 1 - OneFx, 5, 4, 3, 4, 2, 1));
    send_matrix(make_matrix(1, 1, 1, 0, 1, 0, 1, 0, 1));
  endtask

  task automatic test_random_with_gaps(int count);
    rmq_pkg::matrix_t m;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 5));
      random_matrix(m);
      send_matrix(m);
    end
  endtask

  task automatic test_back_to_back(int count);
    rmq_pkg::matrix_t m;
    for (int i = 0; i < count; i++) begin
      random_matrix(m);
      send_matrix(m);
    end
  endtask

  // ---------------- checking ----------------

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_quats.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected quaternion w=%0d x=%0d y=%0d z=%0d", quat_o.quat_w,
                   quat_o.quat_x, quat_o.quat_y, quat_o.quat_z);
        mismatch_count++;
      end else begin
        expected_quat = pending_quats.pop_front();
        if (quat_o.quat_w !== expected_quat.quat_w || quat_o.quat_x !== expected_quat.quat_x ||
            quat_o.quat_y !== expected_quat.quat_y || quat_o.quat_z !== expected_quat.quat_z)
        begin
          if (mismatch_count < 10)
            $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                     expected_quat.quat_w, expected_quat.quat_x, expected_quat.quat_y,
                     expected_quat.quat_z, quat_o.quat_w, quat_o.quat_x, quat_o.quat_y,
                     quat_o.quat_z);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    matrix_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_with_gaps(530);
    test_back_to_back(120);
    start_i <= 1'b0;

    while (pending_quats.size() > 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
    if (pending_quats.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("[rotation_matrix_to_quaternion_top] OK");
    end else begin
      $display("[rotation_matrix_to_quaternion_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[rotation_matrix_to_quaternion_top] ERROR");
    $finish;
  end

endmodule
